### src/bls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types, constants and helpers of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int MAX_WIDTH  = 8;

    localparam int OUT_BITS   = COORD_BITS + 1;
    localparam int TWICE_BITS = COORD_BITS + 2;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int WIDTH_BITS = 4;
    localparam int WIDTH_CAP  = (MAX_WIDTH < 8) ? MAX_WIDTH : 8;
    localparam int CNT_BITS   = (WIDTH_CAP > 1) ? $clog2(WIDTH_CAP) : 1;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);

    localparam int APB_ADDR_BITS = 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [APB_ADDR_BITS-1:0] ADDR_LINE_WIDTH = '0;
    localparam logic [WIDTH_BITS-1:0]    WIDTH_RESET     = WIDTH_BITS'(1);

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    typedef logic [CNT_BITS-1:0] t_cnt;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic                       done;
    } t_point;

    // Number of copies per point, minus one, after clamping the register.
    function automatic t_cnt copies_m1(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] n;
        n = w;
        if (n == '0) begin
            n = WIDTH_BITS'(1);
        end
        if (n > WIDTH_BITS'(WIDTH_CAP)) begin
            n = WIDTH_BITS'(WIDTH_CAP);
        end
        n = n - WIDTH_BITS'(1);
        return n[CNT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### src/bresenham_line_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer line stepper: loads endpoints, walks the line one point per step
// item and emits each point as a short diagonal run of fragments.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// input     push / full                  opcode, x_start, y_start, x_end, y_end
// result    empty / pop                  pixel_x, pixel_y, last_of_point, line_done
// config    psel, penable, pwrite/pready line_width at byte address 0
//
// A start or step item is taken while push is high and full is low; a step on
// a running line issues one point into a four-entry point queue, which the
// back end turns into line_width results (clamped to 1..8), one per cycle
// while pop is held high. Sustained input rate is one item per cycle while the
// queue has room; the result drain limits it for wider lines. full follows the
// point queue. Synchronous reset clears line state and queue, line_width to one.
// ----------------------------------------------------------------------------
module bresenham_line_stepper (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     push,
    output logic                                          full,
    input  wire logic                                     i_opcode,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0]    i_x_start,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0]    i_y_start,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0]    i_x_end,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0]    i_y_end,
    output logic                                          empty,
    input  wire logic                                     pop,
    output logic signed [bls_pkg::OUT_BITS-1:0]           o_pixel_x,
    output logic signed [bls_pkg::OUT_BITS-1:0]           o_pixel_y,
    output logic                                          o_last_of_point,
    output logic                                          o_line_done,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [bls_pkg::APB_ADDR_BITS-1:0]        paddr,
    input  wire logic [bls_pkg::APB_DATA_BITS-1:0]        pwdata,
    output logic [bls_pkg::APB_DATA_BITS-1:0]             prdata,
    output logic                                          pready
);
    import bls_pkg::*;

    logic [WIDTH_BITS-1:0] r_line_width;
    logic                  accept;
    logic                  pt_push;
    t_point                pt;
    logic                  q_pop;
    logic                  q_empty;
    t_point                q_data;
    t_cnt                  copies;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LINE_WIDTH) ?
                    APB_DATA_BITS'(r_line_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WIDTH_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == ADDR_LINE_WIDTH)) begin
            r_line_width <= pwdata[WIDTH_BITS-1:0];
        end
    end

    assign copies = copies_m1(r_line_width);
    assign accept = push && !full;

    bls_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (i_opcode),
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_pt_push (pt_push),
        .o_pt      (pt)
    );

    bls_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pt_push),
        .i_data  (pt),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    bls_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_copies_m1     (copies),
        .i_q_empty       (q_empty),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_point (o_last_of_point),
        .o_line_done     (o_line_done)
    );

    // An issued point is waiting in the queue or the back end on the next cycle.
    a_point_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pt_push |=> !q_empty || (q_pop && $past(q_empty)) || !empty)
        else $error("issued point was lost");

    // Within a run, each further copy sits one step along the diagonal.
    a_diag_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_point) |=>
        (!empty && (o_pixel_x == $past(o_pixel_x) + OUT_BITS'(1)) &&
         (o_pixel_y == $past(o_pixel_y) + OUT_BITS'(1))))
        else $error("diagonal copy out of sequence");

    // The done mark is constant over one run.
    a_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_point) |=> (o_line_done == $past(o_line_done)))
        else $error("line_done changed within a run");

endmodule
`default_nettype wire

### src/bls_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bls_front
// Accepts start and step items, holds the Bresenham state and issues points.
// ----------------------------------------------------------------------------
module bls_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic                                 i_opcode,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0] i_x_start,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0] i_y_start,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0] i_x_end,
    input  wire logic signed [bls_pkg::COORD_BITS-1:0] i_y_end,
    output logic                                      o_pt_push,
    output bls_pkg::t_point                           o_pt
);
    import bls_pkg::*;

    logic                       r_busy, n_busy;
    logic [OUT_BITS-1:0]        r_x, n_x;
    logic [OUT_BITS-1:0]        r_y, n_y;
    logic [ERR_BITS-1:0]        r_err, n_err;
    logic [OUT_BITS-1:0]        r_steps, n_steps;
    logic [TWICE_BITS-1:0]      r_tdx, n_tdx;
    logic [TWICE_BITS-1:0]      r_tdy, n_tdy;
    logic                       r_xneg, n_xneg;
    logic                       r_yneg, n_yneg;
    logic                       r_steep, n_steep;

    logic [OUT_BITS-1:0]        xs, ys, xe, ye;
    logic [OUT_BITS-1:0]        dx, dy, adx, ady;
    logic [TWICE_BITS-1:0]      tdx, tdy;
    logic                       steep;
    logic                       is_step;
    logic                       done;
    logic                       err_le0;
    logic [OUT_BITS-1:0]        x_inc, y_inc;

    assign xs = {i_x_start[COORD_BITS-1], i_x_start};
    assign ys = {i_y_start[COORD_BITS-1], i_y_start};
    assign xe = {i_x_end[COORD_BITS-1], i_x_end};
    assign ye = {i_y_end[COORD_BITS-1], i_y_end};
    assign dx = xe - xs;
    assign dy = ye - ys;
    assign adx = dx[OUT_BITS-1] ? (~dx + OUT_BITS'(1)) : dx;
    assign ady = dy[OUT_BITS-1] ? (~dy + OUT_BITS'(1)) : dy;
    assign tdx = {adx, 1'b0};
    assign tdy = {ady, 1'b0};
    assign steep = ady > adx;

    assign is_step = i_accept && (i_opcode == OP_STEP);
    assign done    = (r_steps == '0);
    assign err_le0 = r_err[ERR_BITS-1] || (r_err == '0);
    // Plus or minus one in two's complement.
    assign x_inc = {{(OUT_BITS-1){r_xneg}}, 1'b1};
    assign y_inc = {{(OUT_BITS-1){r_yneg}}, 1'b1};

    assign o_pt_push = is_step && r_busy;
    assign o_pt.x    = r_x;
    assign o_pt.y    = r_y;
    assign o_pt.done = done;

    always_comb begin
        n_busy  = r_busy;
        n_x     = r_x;
        n_y     = r_y;
        n_err   = r_err;
        n_steps = r_steps;
        n_tdx   = r_tdx;
        n_tdy   = r_tdy;
        n_xneg  = r_xneg;
        n_yneg  = r_yneg;
        n_steep = r_steep;
        if (i_accept && (i_opcode == OP_START)) begin
            n_busy  = 1'b1;
            n_x     = xs;
            n_y     = ys;
            n_tdx   = tdx;
            n_tdy   = tdy;
            n_xneg  = dx[OUT_BITS-1];
            n_yneg  = dy[OUT_BITS-1];
            n_steep = steep;
            if (steep) begin
                n_err   = ERR_BITS'(tdx) - ERR_BITS'(ady);
                n_steps = ady;
            end else begin
                n_err   = ERR_BITS'(tdy) - ERR_BITS'(adx);
                n_steps = adx;
            end
        end else if (o_pt_push) begin
            if (done) begin
                n_busy = 1'b0;
            end else begin
                n_steps = r_steps - OUT_BITS'(1);
                if (!r_steep) begin
                    n_x = r_x + x_inc;
                    if (err_le0) begin
                        n_err = r_err + ERR_BITS'(r_tdy);
                    end else begin
                        n_y   = r_y + y_inc;
                        n_err = r_err + ERR_BITS'(r_tdy) - ERR_BITS'(r_tdx);
                    end
                end else begin
                    n_y = r_y + y_inc;
                    if (err_le0) begin
                        n_err = r_err + ERR_BITS'(r_tdx);
                    end else begin
                        n_x   = r_x + x_inc;
                        n_err = r_err + ERR_BITS'(r_tdx) - ERR_BITS'(r_tdy);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_err   <= '0;
            r_steps <= '0;
            r_tdx   <= '0;
            r_tdy   <= '0;
            r_xneg  <= 1'b0;
            r_yneg  <= 1'b0;
            r_steep <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_x     <= n_x;
            r_y     <= n_y;
            r_err   <= n_err;
            r_steps <= n_steps;
            r_tdx   <= n_tdx;
            r_tdy   <= n_tdy;
            r_xneg  <= n_xneg;
            r_yneg  <= n_yneg;
            r_steep <= n_steep;
        end
    end

endmodule
`default_nettype wire

### src/bls_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bls_fifo
// Short point queue between the stepping front and the copy back end.
// ----------------------------------------------------------------------------
module bls_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bls_pkg::t_point i_data,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output bls_pkg::t_point      o_data
);
    import bls_pkg::*;

    t_point              r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr, n_wr;
    logic [PTR_BITS-1:0] r_rd, n_rd;
    logic [PTR_BITS:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == (PTR_BITS+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + PTR_BITS'(1) : r_wr;
        n_rd  = do_pop ? r_rd + PTR_BITS'(1) : r_rd;
        n_cnt = r_cnt + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### src/bls_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bls_back
// Expands each queued point into its diagonal run of result items.
// ----------------------------------------------------------------------------
module bls_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bls_pkg::t_cnt   i_copies_m1,
    input  wire logic            i_q_empty,
    input  wire bls_pkg::t_point i_q_data,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic signed [bls_pkg::OUT_BITS-1:0] o_pixel_x,
    output logic signed [bls_pkg::OUT_BITS-1:0] o_pixel_y,
    output logic                 o_last_of_point,
    output logic                 o_line_done
);
    import bls_pkg::*;

    logic                r_valid, n_valid;
    logic [OUT_BITS-1:0] r_px, n_px;
    logic [OUT_BITS-1:0] r_py, n_py;
    t_cnt                r_left, n_left;
    logic                r_done, n_done;
    logic                advance;

    // r_left counts the copies still to come after the one on show.
    assign advance = r_valid && i_pop && (r_left != '0);
    assign o_q_pop = (!r_valid || (i_pop && (r_left == '0))) && !i_q_empty;

    assign o_empty         = !r_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_last_of_point = (r_left == '0);
    assign o_line_done     = r_done;

    always_comb begin
        n_valid = r_valid;
        n_px    = r_px;
        n_py    = r_py;
        n_left  = r_left;
        n_done  = r_done;
        if (advance) begin
            n_px   = r_px + OUT_BITS'(1);
            n_py   = r_py + OUT_BITS'(1);
            n_left = r_left - CNT_BITS'(1);
        end else if (o_q_pop) begin
            n_valid = 1'b1;
            n_px    = i_q_data.x;
            n_py    = i_q_data.y;
            n_done  = i_q_data.done;
            n_left  = i_copies_m1;
        end else if (r_valid && i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else begin
            r_valid <= n_valid;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px   <= n_px;
        r_py   <= n_py;
        r_done <= n_done;
    end

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Bresenham line stepper. Start and step items
// go in through the push/full queue with random gaps. The block's own line
// state is tracked alongside to predict every fragment. Each popped fragment
// is checked against the oldest prediction. line_width is rewritten over the
// APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb;
    import bls_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 25;

    typedef struct {
        logic signed [OUT_BITS-1:0] x;
        logic signed [OUT_BITS-1:0] y;
        logic                       last;
        logic                       done;
    } t_fragment;

    class fragment_board;
        logic [WIDTH_BITS-1:0]        line_width;
        logic                         busy;
        logic signed [OUT_BITS-1:0]   cur_x;
        logic signed [OUT_BITS-1:0]   cur_y;
        logic signed [ERR_BITS-1:0]   err;
        logic [OUT_BITS-1:0]          steps_left;
        logic signed [TWICE_BITS-1:0] twice_dx;
        logic signed [TWICE_BITS-1:0] twice_dy;
        logic                         x_neg;
        logic                         y_neg;
        logic                         steep;
        t_fragment                    due[$];
        int                           mismatches;

        function new();
            line_width = WIDTH_RESET;
            busy       = 1'b0;
            cur_x      = '0;
            cur_y      = '0;
            err        = '0;
            steps_left = '0;
            twice_dx   = '0;
            twice_dy   = '0;
            x_neg      = 1'b0;
            y_neg      = 1'b0;
            steep      = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // Notes one accepted item and queues the fragments it gives rise to.
        task take_item(input t_opcode op, input int xs, input int ys,
                       input int xe, input int ye);
            int        dx;
            int        dy;
            int        n;
            t_fragment f;
            if (op == OP_START) begin
                dx    = xe - xs;
                dy    = ye - ys;
                x_neg = (dx < 0);
                y_neg = (dy < 0);
                if (x_neg) begin
                    dx = -dx;
                end
                if (y_neg) begin
                    dy = -dy;
                end
                twice_dx = TWICE_BITS'(2 * dx);
                twice_dy = TWICE_BITS'(2 * dy);
                cur_x    = OUT_BITS'(xs);
                cur_y    = OUT_BITS'(ys);
                steep    = (dy > dx);
                if (!steep) begin
                    err        = ERR_BITS'(2 * dy - dx);
                    steps_left = OUT_BITS'(dx);
                end else begin
                    err        = ERR_BITS'(2 * dx - dy);
                    steps_left = OUT_BITS'(dy);
                end
                busy = 1'b1;
            end else if (busy) begin
                n = int'(line_width);
                if (n == 0) begin
                    n = 1;
                end
                if (n > WIDTH_CAP) begin
                    n = WIDTH_CAP;
                end
                for (int j = 0; j < n; j++) begin
                    f.x    = OUT_BITS'(cur_x + j);
                    f.y    = OUT_BITS'(cur_y + j);
                    f.last = (j == n - 1);
                    f.done = (steps_left == 0);
                    due.insert(due.size(), f);
                end
                if (steps_left == 0) begin
                    busy = 1'b0;
                end else begin
                    steps_left = steps_left - 1'b1;
                    // A zero error term is a tie: the minor axis stays put.
                    if (!steep) begin
                        cur_x = x_neg ? cur_x - OUT_BITS'(1) : cur_x + OUT_BITS'(1);
                        if (err <= 0) begin
                            err = err + twice_dy;
                        end else begin
                            cur_y = y_neg ? cur_y - OUT_BITS'(1) : cur_y + OUT_BITS'(1);
                            err   = err + twice_dy - twice_dx;
                        end
                    end else begin
                        cur_y = y_neg ? cur_y - OUT_BITS'(1) : cur_y + OUT_BITS'(1);
                        if (err <= 0) begin
                            err = err + twice_dx;
                        end else begin
                            cur_x = x_neg ? cur_x - OUT_BITS'(1) : cur_x + OUT_BITS'(1);
                            err   = err + twice_dx - twice_dy;
                        end
                    end
                end
            end
        endtask

        task check_fragment(input logic signed [OUT_BITS-1:0] x,
                            input logic signed [OUT_BITS-1:0] y,
                            input logic last, input logic done);
            t_fragment f;
            if (due.size() == 0) begin
                flag_mismatch($sformatf("unexpected fragment at (%0d, %0d)", x, y));
            end else begin
                f = due[0];
                due.delete(0);
                if (x !== f.x) begin
                    flag_mismatch($sformatf("pixel_x %0d, expected %0d", x, f.x));
                end
                if (y !== f.y) begin
                    flag_mismatch($sformatf("pixel_y %0d, expected %0d", y, f.y));
                end
                if (last !== f.last) begin
                    flag_mismatch($sformatf("last_of_point %b, expected %b at (%0d, %0d)",
                                            last, f.last, f.x, f.y));
                end
                if (done !== f.done) begin
                    flag_mismatch($sformatf("line_done %b, expected %b at (%0d, %0d)",
                                            done, f.done, f.x, f.y));
                end
            end
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n   = 1'b0;
    logic                         push      = 1'b0;
    logic                         pop       = 1'b0;
    logic                         i_opcode  = 1'b0;
    logic signed [COORD_BITS-1:0] i_x_start = '0;
    logic signed [COORD_BITS-1:0] i_y_start = '0;
    logic signed [COORD_BITS-1:0] i_x_end   = '0;
    logic signed [COORD_BITS-1:0] i_y_end   = '0;
    logic                         psel      = 1'b0;
    logic                         penable   = 1'b0;
    logic                         pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0]     paddr     = '0;
    logic [APB_DATA_BITS-1:0]     pwdata    = '0;

    logic                         full;
    logic                         empty;
    logic signed [OUT_BITS-1:0]   o_pixel_x;
    logic signed [OUT_BITS-1:0]   o_pixel_y;
    logic                         o_last_of_point;
    logic                         o_line_done;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    bit            calm      = 1'b0;
    int            cycles    = 0;
    int            pop_stall = 0;
    fragment_board board;

    bresenham_line_stepper u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_x_start       (i_x_start),
        .i_y_start       (i_y_start),
        .i_x_end         (i_x_end),
        .i_y_end         (i_y_end),
        .empty           (empty),
        .pop             (pop),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_last_of_point (o_last_of_point),
        .o_line_done     (o_line_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // A coordinate a few pixels from base, folded back inside the screen.
    function automatic int near(input int base);
        int v;
        v = base + int'($urandom_range(0, 24)) - 12;
        if (v > 2047 || v < -2048) begin
            v = 2 * base - v;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else begin
            pop <= 1'b1;
            pop_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            board.check_fragment(o_pixel_x, o_pixel_y, o_last_of_point, o_line_done);
        end
    end

    task automatic push_item(input t_opcode op, input int xs, input int ys,
                             input int xe, input int ye);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_opcode  <= op;
        i_x_start <= COORD_BITS'(xs);
        i_y_start <= COORD_BITS'(ys);
        i_x_end   <= COORD_BITS'(xe);
        i_y_end   <= COORD_BITS'(ye);
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.take_item(op, xs, ys, xe, ye);
    endtask

    // The endpoint fields of a step item are don't-care, so they carry noise.
    task automatic push_step();
        push_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic settle();
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_line_width(input logic [WIDTH_BITS-1:0] w);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= ADDR_LINE_WIDTH;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DATA_BITS'(w)) begin
            board.flag_mismatch($sformatf("line_width reads %0h, expected %0h", prdata, w));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_line_width(input logic [WIDTH_BITS-1:0] w);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_LINE_WIDTH;
        // Bits above the register are junk and must be dropped.
        pwdata  <= ($urandom() & ~APB_DATA_BITS'(4'hF)) | APB_DATA_BITS'(w);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.line_width = w;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        read_line_width(w);
    endtask

    task automatic random_phase(input int n_items);
        int counted;
        int r;
        int xs;
        int ys;
        int xe;
        int ye;
        int pts;
        counted = 0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                if (board.busy) begin
                    counted++;
                end
                push_step();
            end else if (r < 16) begin
                // Long line across the screen, dropped after a few points.
                push_item(OP_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
                counted++;
                pts = $urandom_range(0, 4);
                repeat (pts) begin
                    if (board.busy) begin
                        counted++;
                    end
                    push_step();
                end
            end else begin
                xs = rand_coord();
                ys = rand_coord();
                xe = near(xs);
                ye = near(ys);
                push_item(OP_START, xs, ys, xe, ye);
                counted++;
                pts = ((xe > xs) ? xe - xs : xs - xe);
                if (((ye > ys) ? ye - ys : ys - ye) > pts) begin
                    pts = (ye > ys) ? ye - ys : ys - ye;
                end
                pts = pts + 1;
                // Now and then cut the line short or run past its end.
                if ($urandom_range(0, 9) == 0) begin
                    pts = $urandom_range(0, pts + 2);
                end
                repeat (pts) begin
                    if (board.busy) begin
                        counted++;
                    end
                    push_step();
                end
            end
        end
    endtask

    initial begin : stimulus
        int widths[5];
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_line_width(WIDTH_RESET);

        // Directed lines at the reset width.
        push_step();                              // idle step, nothing comes out
        push_item(OP_START, 5, -7, 5, -7);        // a single point
        push_step();
        push_item(OP_START, 0, 0, 2, 1);          // shallow line with a tie on the error term
        repeat (3) push_step();
        push_item(OP_START, 3, 3, 2, -1);         // steep, both directions negative
        repeat (5) push_step();
        push_item(OP_START, -2048, -2048, 2047, 2047);
        repeat (2) push_step();
        push_item(OP_START, 2047, 2047, 2047, -2048);  // replaces a running line
        push_step();
        push_item(OP_START, 2047, -2048, 2046, -2048);
        repeat (2) push_step();
        push_step();                              // past the end of the line
        settle();

        // Width above the cap saturates; the diagonal runs past the screen edge.
        write_line_width(4'hF);
        push_item(OP_START, 2047, 2047, 2047, 2047);
        push_step();
        settle();

        widths = '{0, 8, int'($urandom_range(2, 7)), 1, int'($urandom_range(9, 14))};
        for (int ph = 0; ph < 5; ph++) begin
            calm = (ph == 2) || ($urandom_range(0, 3) == 0);
            write_line_width(WIDTH_BITS'(widths[ph]));
            random_phase(ITEMS_PER_PHASE);
            settle();
        end
        calm = 1'b0;

        if (board.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
